// ===== rtl/sfe_pkg.sv =====
// Shared types, codes and default sizes for the SPI slave frame engine.
package sfe_pkg;

  localparam int RX_CAPACITY_DEFAULT = 32;
  localparam int TX_CAPACITY_DEFAULT = 32;

  typedef enum logic [1:0] {
    CMD_EXCHANGE    = 2'd0,
    CMD_LOAD_HEADER = 2'd1,
    CMD_LOAD_DATA   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    FIELD_NONE    = 2'd0,
    FIELD_COMMAND = 2'd1,
    FIELD_LENGTH  = 2'd2,
    FIELD_PAYLOAD = 2'd3
  } rx_field_t;

  typedef struct packed {
    rx_field_t   field;
    logic [7:0]  value;
    logic [4:0]  data_index;
    logic        frame_end;
    logic [7:0]  frame_command;
    logic [5:0]  frame_length;
  } rx_result_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       load_rejected;
  } tx_result_t;

endpackage

// ===== rtl/sfe_rx.sv =====
// Receive framer: command, length and payload tracking for each exchanged byte.
module sfe_rx #(
  parameter int RX_CAPACITY = sfe_pkg::RX_CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                exchange,
  input  logic [7:0]          rx_byte,
  output sfe_pkg::rx_result_t result
);

  localparam int PW = $clog2(RX_CAPACITY + 3);
  localparam int LW = $clog2(RX_CAPACITY + 1);

  logic [PW-1:0] position, position_next;
  logic [LW-1:0] length, length_next;
  logic [7:0]    command, command_next;

  logic              opening;
  logic [PW-1:0]     pos_open;
  logic [LW-1:0]     len_open;
  logic [LW-1:0]     len_clamp;
  logic [LW-1:0]     len_after;
  logic              done;
  logic [PW-1:0]     pos_after;
  logic [7:0]        index_wide;
  logic [7:0]        length_wide;
  sfe_pkg::rx_field_t field;

  always_comb begin
    // a nonzero byte while idle opens a frame as its command byte
    opening   = (position == '0) && (rx_byte != 8'd0);
    pos_open  = opening ? PW'(1) : position;
    len_open  = opening ? '0 : length;
    len_clamp = (rx_byte > 8'(RX_CAPACITY)) ? '0 : LW'(rx_byte);
    len_after = (pos_open == PW'(2)) ? len_clamp : len_open;
    done      = (pos_open != '0) && (pos_open >= PW'(len_after) + PW'(2));
    if (done) begin
      pos_after = '0;
    end else if (pos_open != '0) begin
      pos_after = pos_open + PW'(1);
    end else begin
      pos_after = '0;
    end
    index_wide = 8'(pos_open) - 8'd3;
    case (pos_open)
      PW'(0):  field = sfe_pkg::FIELD_NONE;
      PW'(1):  field = sfe_pkg::FIELD_COMMAND;
      PW'(2):  field = sfe_pkg::FIELD_LENGTH;
      default: field = sfe_pkg::FIELD_PAYLOAD;
    endcase
  end

  always_comb begin
    position_next = position;
    length_next   = length;
    command_next  = command;
    if (exchange) begin
      position_next = pos_after;
      length_next   = len_after;
      if (pos_open == PW'(1)) begin
        command_next = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      length   <= '0;
      command  <= '0;
    end else begin
      position <= position_next;
      length   <= length_next;
      command  <= command_next;
    end
  end

  always_comb begin
    length_wide          = 8'(length_next);
    result.field         = exchange ? field : sfe_pkg::FIELD_NONE;
    result.value         = (exchange && field != sfe_pkg::FIELD_NONE) ? rx_byte : 8'd0;
    result.data_index    = (exchange && field == sfe_pkg::FIELD_PAYLOAD) ? index_wide[4:0]
                                                                         : 5'd0;
    result.frame_end     = exchange && done;
    result.frame_command = command_next;
    result.frame_length  = length_wide[5:0];
  end

endmodule

// ===== rtl/sfe_tx.sv =====
// Transmit side: header and data loading into a byte buffer, then byte sequencing.
module sfe_tx #(
  parameter int TX_CAPACITY = sfe_pkg::TX_CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                exchange,
  input  logic                load_header,
  input  logic                load_data,
  input  logic [7:0]          tx_address,
  input  logic [5:0]          tx_length,
  input  logic [7:0]          tx_data,
  output sfe_pkg::tx_result_t result
);

  localparam int LW = $clog2(TX_CAPACITY + 1);
  localparam int RW = $clog2(TX_CAPACITY + 3);
  localparam int AW = (TX_CAPACITY > 1) ? $clog2(TX_CAPACITY) : 1;

  logic [7:0]    mem [TX_CAPACITY];
  logic [7:0]    rd_data;

  logic [7:0]    hdr_addr, hdr_addr_next;
  logic [LW-1:0] hdr_len, hdr_len_next;
  logic [RW-1:0] remaining, remaining_next;
  logic [LW-1:0] wptr, wptr_next;
  logic          loading, loading_next;

  logic          busy;
  logic          write_en;
  logic          rejected;
  logic [7:0]    byte_out;
  logic [RW-1:0] len_ext;
  logic [RW-1:0] rd_idx_wide;
  logic          rd_ok;

  always_comb begin
    hdr_addr_next  = hdr_addr;
    hdr_len_next   = hdr_len;
    remaining_next = remaining;
    wptr_next      = wptr;
    loading_next   = loading;
    write_en       = 1'b0;
    rejected       = 1'b0;
    byte_out       = 8'd0;
    busy           = loading || (remaining != '0);
    len_ext        = RW'(hdr_len);

    if (load_header) begin
      if (busy || (8'(tx_length) > 8'(TX_CAPACITY))) begin
        rejected = 1'b1;
      end else begin
        hdr_addr_next = tx_address;
        hdr_len_next  = LW'(tx_length);
        wptr_next     = '0;
        if (tx_length == 6'd0) begin
          loading_next   = 1'b0;
          remaining_next = RW'(2);
        end else begin
          loading_next = 1'b1;
        end
      end
    end

    if (load_data) begin
      if (!loading || (wptr >= LW'(TX_CAPACITY))) begin
        rejected = 1'b1;
      end else begin
        write_en  = 1'b1;
        wptr_next = wptr + LW'(1);
        // last byte loaded: arm the frame
        if (wptr_next >= hdr_len) begin
          loading_next   = 1'b0;
          remaining_next = len_ext + RW'(2);
        end
      end
    end

    if (exchange && (remaining != '0)) begin
      if (remaining == len_ext + RW'(2)) begin
        byte_out = hdr_addr;
      end else if (remaining == len_ext + RW'(1)) begin
        byte_out = 8'(hdr_len);
      end else if ((remaining <= len_ext) && (hdr_addr != 8'd0)) begin
        byte_out = rd_data;
      end
      remaining_next = remaining - RW'(1);
    end

    // prefetch the buffer entry the next state points at
    rd_idx_wide = RW'(hdr_len_next) - remaining_next;
    rd_ok       = rd_idx_wide < RW'(TX_CAPACITY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_addr  <= '0;
      hdr_len   <= '0;
      remaining <= '0;
      wptr      <= '0;
      loading   <= 1'b0;
    end else begin
      hdr_addr  <= hdr_addr_next;
      hdr_len   <= hdr_len_next;
      remaining <= remaining_next;
      wptr      <= wptr_next;
      loading   <= loading_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[wptr[AW-1:0]] <= tx_data;
    end
    if (rd_ok) begin
      rd_data <= mem[rd_idx_wide[AW-1:0]];
    end
  end

  assign result.tx_byte       = byte_out;
  assign result.load_rejected = rejected;

endmodule

// ===== rtl/spi_slave_frame_engine.sv =====
// Top level of the SPI slave frame engine: request decode, both sides, result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | to block  | in_valid / in_stall | command, rx_byte, tx_address, tx_length,
//           |           |                     | tx_data
//   out     | from block| out_valid/out_stall | tx_byte, rx_field, rx_value, data_index,
//           |           |                     | frame_end, frame_command, frame_length,
//           |           |                     | load_rejected
//
// One request per cycle unless a held result stalls it; the result appears in the cycle
// after acceptance, from the single result register behind the receive framer and
// transmit sequencer. The transmit buffer is a memory with a registered read that
// prefetches the entry the sequencer will need next, so payload bytes need no read wait.
// Reset (rst, synchronous) idles both sides and empties the result register; the
// buffer contents are not cleared and are only used for output after being loaded.
// in_stall is high only while a result is held and out_stall is high; a result held
// under stall stays unchanged, and a new request is taken in the cycle it drains.
module spi_slave_frame_engine #(
  parameter int RX_CAPACITY = sfe_pkg::RX_CAPACITY_DEFAULT,
  parameter int TX_CAPACITY = sfe_pkg::TX_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] rx_byte,
  input  logic [7:0] tx_address,
  input  logic [5:0] tx_length,
  input  logic [7:0] tx_data,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic [1:0] rx_field,
  output logic [7:0] rx_value,
  output logic [4:0] data_index,
  output logic       frame_end,
  output logic [7:0] frame_command,
  output logic [5:0] frame_length,
  output logic       load_rejected
);

  logic                accept;
  logic                do_exchange;
  logic                do_header;
  logic                do_data;
  logic                out_valid_next;
  sfe_pkg::rx_result_t rx_res;
  sfe_pkg::tx_result_t tx_res;

  // take a request whenever the result register is empty or draining this cycle
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // decode the request; the unused code touches neither side
  always_comb begin
    do_exchange = 1'b0;
    do_header   = 1'b0;
    do_data     = 1'b0;
    unique case (sfe_pkg::cmd_t'(command))
      sfe_pkg::CMD_EXCHANGE:    do_exchange = accept;
      sfe_pkg::CMD_LOAD_HEADER: do_header   = accept;
      sfe_pkg::CMD_LOAD_DATA:   do_data     = accept;
      default: begin
      end
    endcase
  end

  sfe_rx #(
    .RX_CAPACITY(RX_CAPACITY)
  ) u_rx (
    .clk      (clk),
    .rst      (rst),
    .exchange (do_exchange),
    .rx_byte  (rx_byte),
    .result   (rx_res)
  );

  sfe_tx #(
    .TX_CAPACITY(TX_CAPACITY)
  ) u_tx (
    .clk         (clk),
    .rst         (rst),
    .exchange    (do_exchange),
    .load_header (do_header),
    .load_data   (do_data),
    .tx_address  (tx_address),
    .tx_length   (tx_length),
    .tx_data     (tx_data),
    .result      (tx_res)
  );

  // result register: fill on accept, hold under stall, drop once taken
  always_comb begin
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_stall) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_byte       <= tx_res.tx_byte;
      rx_field      <= rx_res.field;
      rx_value      <= rx_res.value;
      data_index    <= rx_res.data_index;
      frame_end     <= rx_res.frame_end;
      frame_command <= rx_res.frame_command;
      frame_length  <= rx_res.frame_length;
      load_rejected <= tx_res.load_rejected;
    end
  end

  // a completed frame always comes from a received byte
  a_end_has_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> rx_field != sfe_pkg::FIELD_NONE)
    else $error("frame_end without a received field");

  // payload position is only reported for payload bytes
  a_index_payload_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_index != 5'd0 |-> rx_field == sfe_pkg::FIELD_PAYLOAD)
    else $error("data_index set outside payload");

  // a load, or the unused code, never produces transmit or receive traffic
  a_load_is_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && command != sfe_pkg::CMD_EXCHANGE |=>
      tx_byte == 8'd0 && rx_field == sfe_pkg::FIELD_NONE && !frame_end)
    else $error("load request produced exchange data");

  // an exchange is never reported as a refused load
  a_exchange_not_rejected: assert property (@(posedge clk) disable iff (rst)
    accept && command == sfe_pkg::CMD_EXCHANGE |=> !load_rejected)
    else $error("exchange flagged as rejected load");

endmodule
